>>> design/rpsh_pkg.sv
package rpsh_pkg;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] REG_FRAME_BETA   = 2'd0;
	localparam logic [1:0] REG_FRAME_IGAMMA = 2'd1;
	localparam logic [1:0] REG_BINS_PER_LEN = 2'd2;
	localparam logic [1:0] REG_SPECIES      = 2'd3;

	localparam int NUM_W = 49;
	localparam int DEN_W = 34;
	localparam int QUO_W = 50;

	typedef struct packed {
		logic       rd;
		logic       inc;
		logic       clr;
		logic [2:0] en;
	} mem_cmd_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [2:0][7:0] data;
	} mem_rsp_t;

endpackage

>>> design/rpsh_chan_if.sv
interface rpsh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] pos_x;
	logic signed [31:0] mom_x;
	logic signed [31:0] mom_y;
	logic signed [31:0] mom_z;
	logic [16:0] inv_gamma;
	logic [7:0]  particle_species;
	logic [8:0]  read_vel_bin;
	logic [8:0]  read_pos_bin;

	modport source (output valid, action, pos_x, mom_x, mom_y, mom_z, inv_gamma,
		particle_species, read_vel_bin, read_pos_bin, input ready);
	modport sink (input valid, action, pos_x, mom_x, mom_y, mom_z, inv_gamma,
		particle_species, read_vel_bin, read_pos_bin, output ready);
endinterface

interface rpsh_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] count_vx;
	logic [7:0] count_vy;
	logic [7:0] count_vz;
	logic [3:0] range_error;

	modport source (output valid, count_vx, count_vy, count_vz, range_error, input ready);
	modport sink (input valid, count_vx, count_vy, count_vz, range_error, output ready);
endinterface

>>> design/rpsh_div.sv
module rpsh_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [rpsh_pkg::NUM_W-1:0] num,
	input  logic signed [rpsh_pkg::DEN_W-1:0] den,
	output logic done,
	output logic signed [rpsh_pkg::QUO_W-1:0] quo
);
	localparam int NW = rpsh_pkg::NUM_W;
	localparam int DW = rpsh_pkg::DEN_W;
	localparam int QW = rpsh_pkg::QUO_W;
	localparam int CW = $clog2(NW + 1);

	logic          run_q;
	logic          fin_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] nm_q;
	logic [DW-1:0] dm_q;
	logic [DW-1:0] rem_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic          fits;
	logic [QW-1:0] qm;

	assign trial = {rem_q, nm_q[NW-1]};
	assign fits  = trial >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1] ^ den[DW-1];
			nm_q  <= num[NW-1] ? NW'(-num) : NW'(num);
			dm_q  <= den[DW-1] ? DW'(-den) : DW'(den);
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dm_q}) : trial[DW-1:0];
			nm_q  <= {nm_q[NW-2:0], fits};
		end
	end

	assign qm   = QW'(nm_q);
	assign done = fin_q;
	assign quo  = neg_q ? $signed(QW'(-qm - QW'(rem_q != '0))) : $signed(qm);

endmodule

>>> design/rpsh_hist_mem.sv
module rpsh_hist_mem #(
	parameter int VEL_BINS = 400,
	parameter int POS_BINS = 400
) (
	input  logic clk,
	input  logic arst_n,
	input  rpsh_pkg::mem_cmd_t cmd,
	input  logic [$clog2(VEL_BINS*POS_BINS)-1:0] addr_vx,
	input  logic [$clog2(VEL_BINS*POS_BINS)-1:0] addr_vy,
	input  logic [$clog2(VEL_BINS*POS_BINS)-1:0] addr_vz,
	output rpsh_pkg::mem_rsp_t rsp
);
	localparam int DEPTH = VEL_BINS * POS_BINS;
	localparam int AW = $clog2(DEPTH);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_INC  = 2'd1;
	localparam logic [1:0] M_CLR  = 2'd2;

	logic [7:0] hist_vx [DEPTH];
	logic [7:0] hist_vy [DEPTH];
	logic [7:0] hist_vz [DEPTH];

	logic [1:0]    mst_q;
	logic          rd_pend_q;
	logic [2:0]    en_q;
	logic [AW-1:0] clr_addr_q;
	logic [7:0]    rd_vx, rd_vy, rd_vz;
	logic          take;
	logic          clearing;
	logic          clr_last;
	logic [2:0]    we;

	assign take     = (mst_q == M_IDLE) && !rd_pend_q;
	assign clearing = mst_q == M_CLR;
	assign clr_last = clearing && (clr_addr_q == AW'(DEPTH - 1));
	assign we       = clearing ? 3'b111 : ((mst_q == M_INC) ? en_q : 3'b000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q      <= M_CLR;
			rd_pend_q  <= 1'b0;
			en_q       <= '0;
			clr_addr_q <= '0;
		end else begin
			rd_pend_q <= take && cmd.rd;
			case (mst_q)
				M_IDLE: begin
					if (take && cmd.inc) begin
						mst_q <= M_INC;
						en_q  <= cmd.en;
					end else if (take && cmd.clr) begin
						mst_q      <= M_CLR;
						clr_addr_q <= '0;
					end
				end
				M_INC: mst_q <= M_IDLE;
				M_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_last) begin
						mst_q <= M_IDLE;
					end
				end
				default: mst_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we[0]) begin
			hist_vx[clearing ? clr_addr_q : addr_vx] <= clearing ? 8'd0 : rd_vx + 8'd1;
		end
		rd_vx <= hist_vx[addr_vx];
	end

	always_ff @(posedge clk) begin
		if (we[1]) begin
			hist_vy[clearing ? clr_addr_q : addr_vy] <= clearing ? 8'd0 : rd_vy + 8'd1;
		end
		rd_vy <= hist_vy[addr_vy];
	end

	always_ff @(posedge clk) begin
		if (we[2]) begin
			hist_vz[clearing ? clr_addr_q : addr_vz] <= clearing ? 8'd0 : rd_vz + 8'd1;
		end
		rd_vz <= hist_vz[addr_vz];
	end

	assign rsp.busy = !take;
	assign rsp.done = (mst_q == M_INC) || rd_pend_q || clr_last;
	assign rsp.data = {rd_vz, rd_vy, rd_vx};

endmodule

>>> design/relativistic_phase_space_histogram_top.sv
// Phase-space histogram with Lorentz boost: each request clears all three 8-bit
// histograms, reads one bin, or adds one particle (vx, vy, vz bins against the
// position bin). An add runs its three 49-step divisions one after another
// through the shared bit-serial divider. A clear, and the pass after reset,
// sweep all VEL_BINS*POS_BINS entries at one per cycle, during which no
// request is taken (configuration still is).
module relativistic_phase_space_histogram_top #(
	parameter int VEL_BINS = 400,
	parameter int POS_BINS = 400
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rpsh_req_if.sink    req,
	rpsh_rsp_if.source  rsp
);
	localparam int VB_W = $clog2(VEL_BINS);
	localparam int PB_W = $clog2(POS_BINS);
	localparam int AW   = $clog2(VEL_BINS * POS_BINS);
	localparam int NW   = rpsh_pkg::NUM_W;
	localparam int DW   = rpsh_pkg::DEN_W;
	localparam int QW   = rpsh_pkg::QUO_W;
	localparam logic signed [13:0] VDM = 14'(VEL_BINS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_MUL1 = 4'd3;
	localparam logic [3:0] S_MUL2 = 4'd4;
	localparam logic [3:0] S_DEN  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_BIN  = 4'd7;
	localparam logic [3:0] S_IDX  = 4'd8;
	localparam logic [3:0] S_UPD  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic signed [16:0] beta_q;
	logic [16:0]        fig_q;
	logic [31:0]        bpl_q;
	logic [7:0]         spec_q;

	logic [3:0] state_q;
	logic [1:0] k_q;
	logic       div_run_q;
	logic       out_valid_q;

	logic [31:0]        px_q;
	logic signed [31:0] ux_q, uy_q, uz_q;
	logic [16:0]        ig_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic [63:0]        pprod_q;
	logic signed [32:0] vyb_q;
	logic signed [NW-1:0] nx_q, ny_q, nz_q;
	logic [PB_W-1:0]    pb_q;
	logic               pos_ok_q;
	logic signed [DW-1:0] d_q;
	logic signed [QW-1:0] quo_q [3];
	logic [VB_W-1:0]    vb_q [3];
	logic [2:0]         ok_q;
	logic [AW-1:0]      idx_q [3];
	logic [2:0]         en_q;
	logic [7:0]         cnt_q [3];
	logic [3:0]         err_q;
	logic [7:0]         out_cnt_q [3];
	logic [3:0]         out_err_q;

	logic acc;
	logic cfg_wr;
	logic rd_err_v, rd_err_p;
	logic [AW-1:0] rd_idx;
	logic d_zero;
	logic div_start, div_done;
	logic signed [NW-1:0] div_num;
	logic signed [QW-1:0] div_quo;
	logic fin_go;
	logic [64:0] pround;
	logic [32:0] pbin;
	logic signed [48:0] pm_x, pm_y, pm_z, pm_b, pm_fx, pm_fz;
	logic signed [32:0] vsum;
	logic [VB_W-1:0] bin_vb [3];
	logic [2:0]      bin_ok;
	logic signed [19:0] bu [3];
	logic signed [33:0] bt [3];
	logic [16:0]        bs [3];
	logic               bin_in [3];
	logic [2:0]         upd_en;
	rpsh_pkg::mem_cmd_t mem_cmd;
	rpsh_pkg::mem_rsp_t mem_rsp;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= '0;
			fig_q  <= 17'd65536;
			bpl_q  <= 32'd65536;
			spec_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rpsh_pkg::REG_FRAME_BETA:   beta_q <= pwdata[16:0];
				rpsh_pkg::REG_FRAME_IGAMMA: fig_q  <= pwdata[16:0];
				rpsh_pkg::REG_BINS_PER_LEN: bpl_q  <= pwdata;
				rpsh_pkg::REG_SPECIES:      spec_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rpsh_pkg::REG_FRAME_BETA:   prdata = 32'(beta_q);
			rpsh_pkg::REG_FRAME_IGAMMA: prdata = 32'(fig_q);
			rpsh_pkg::REG_BINS_PER_LEN: prdata = bpl_q;
			rpsh_pkg::REG_SPECIES:      prdata = 32'(spec_q);
			default:                    prdata = '0;
		endcase
	end

	// request side
	assign req.ready = (state_q == S_IDLE) && !mem_rsp.busy;
	assign acc       = req.valid && req.ready;
	assign rd_err_v  = 13'(req.read_vel_bin) >= 13'(VEL_BINS);
	assign rd_err_p  = 13'(req.read_pos_bin) >= 13'(POS_BINS);
	assign rd_idx    = AW'(32'(req.read_vel_bin) * 32'(POS_BINS) + 32'(req.read_pos_bin));

	// datapath arithmetic
	assign pm_x  = 49'(ux_q) * 49'($signed({1'b0, ig_q}));
	assign pm_y  = 49'(uy_q) * 49'($signed({1'b0, ig_q}));
	assign pm_z  = 49'(uz_q) * 49'($signed({1'b0, ig_q}));
	assign pm_b  = 49'(vy_q) * 49'(beta_q);
	assign pm_fx = 49'(vx_q) * 49'($signed({1'b0, fig_q}));
	assign pm_fz = 49'(vz_q) * 49'($signed({1'b0, fig_q}));
	assign vsum  = 33'(vy_q) + 33'(beta_q);
	assign pround = {1'b0, pprod_q} + 65'h0_8000_0000;
	assign pbin   = pround[64:32];
	assign d_zero = d_q == '0;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bin_in[k] = (quo_q[k] >= -(QW'(262144))) && (quo_q[k] < QW'(262144));
			bu[k]     = 20'($signed(quo_q[k][18:0])) + 20'sd65536;
			bt[k]     = 34'(bu[k]) * 34'(VDM) + 34'sd65536;
			bs[k]     = bt[k][33:17];
			bin_ok[k] = bin_in[k] && !bs[k][16] && ({1'b0, bs[k][15:0]} < 17'(VEL_BINS));
			bin_vb[k] = bs[k][VB_W-1:0];
		end
	end

	assign upd_en = ok_q & {3{pos_ok_q}};

	always_comb begin
		case (k_q)
			2'd0:    div_num = nx_q;
			2'd1:    div_num = ny_q;
			default: div_num = nz_q;
		endcase
	end

	assign div_start = (state_q == S_DIV) && !d_zero && !div_run_q;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	rpsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign mem_cmd.rd  = state_q == S_RD;
	assign mem_cmd.inc = state_q == S_UPD;
	assign mem_cmd.clr = state_q == S_CLR;
	assign mem_cmd.en  = en_q;

	rpsh_hist_mem #(
		.VEL_BINS (VEL_BINS),
		.POS_BINS (POS_BINS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.addr_vx (idx_q[0]),
		.addr_vy (idx_q[1]),
		.addr_vz (idx_q[2]),
		.rsp     (mem_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			div_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.action)
							rpsh_pkg::ACT_CLEAR: state_q <= S_CLR;
							rpsh_pkg::ACT_READ:
								state_q <= (rd_err_v || rd_err_p) ? S_FIN : S_RD;
							rpsh_pkg::ACT_ADD:
								state_q <= (req.particle_species == spec_q) ? S_MUL1 : S_FIN;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CLR, S_RD, S_UPD: begin
					if (mem_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DEN;
				S_DEN: begin
					state_q   <= S_DIV;
					k_q       <= '0;
					div_run_q <= 1'b0;
				end
				S_DIV: begin
					if (d_zero) begin
						state_q <= S_IDX;
					end else if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						if (k_q == 2'd2) begin
							state_q <= S_BIN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_BIN: state_q <= S_IDX;
				S_IDX: state_q <= (|(ok_q & {3{pos_ok_q}})) ? S_UPD : S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					px_q     <= req.pos_x;
					ux_q     <= req.mom_x;
					uy_q     <= req.mom_y;
					uz_q     <= req.mom_z;
					ig_q     <= req.inv_gamma;
					cnt_q[0] <= '0;
					cnt_q[1] <= '0;
					cnt_q[2] <= '0;
					en_q     <= '0;
					idx_q[0] <= rd_idx;
					idx_q[1] <= rd_idx;
					idx_q[2] <= rd_idx;
					if (req.action == rpsh_pkg::ACT_READ) begin
						err_q <= {rd_err_p, {3{rd_err_v}}};
					end else begin
						err_q <= '0;
					end
				end
			end
			S_RD: begin
				if (mem_rsp.done) begin
					cnt_q[0] <= mem_rsp.data[0];
					cnt_q[1] <= mem_rsp.data[1];
					cnt_q[2] <= mem_rsp.data[2];
				end
			end
			S_MUL1: begin
				vx_q    <= pm_x[47:16];
				vy_q    <= pm_y[47:16];
				vz_q    <= pm_z[47:16];
				pprod_q <= 64'(px_q) * 64'(bpl_q);
			end
			S_MUL2: begin
				vyb_q    <= pm_b[48:16];
				nx_q     <= pm_fx;
				nz_q     <= pm_fz;
				ny_q     <= {vsum[32:0], 16'd0};
				pos_ok_q <= pbin < 33'(POS_BINS);
				pb_q     <= pbin[PB_W-1:0];
			end
			S_DEN: d_q <= DW'(vyb_q) + DW'(65536);
			S_DIV: begin
				if (d_zero) begin
					ok_q       <= '0;
					err_q[2:0] <= 3'b111;
				end else if (div_run_q && div_done) begin
					quo_q[k_q] <= div_quo;
				end
			end
			S_BIN: begin
				for (int k = 0; k < 3; k++) begin
					vb_q[k] <= bin_vb[k];
				end
				ok_q       <= bin_ok;
				err_q[2:0] <= ~bin_ok;
			end
			S_IDX: begin
				for (int k = 0; k < 3; k++) begin
					idx_q[k] <= AW'(32'(vb_q[k]) * 32'(POS_BINS) + 32'(pb_q));
				end
				en_q     <= upd_en;
				err_q[3] <= !pos_ok_q;
			end
			S_FIN: begin
				if (fin_go) begin
					out_cnt_q[0] <= cnt_q[0];
					out_cnt_q[1] <= cnt_q[1];
					out_cnt_q[2] <= cnt_q[2];
					out_err_q    <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.count_vx    = out_cnt_q[0];
	assign rsp.count_vy    = out_cnt_q[1];
	assign rsp.count_vz    = out_cnt_q[2];
	assign rsp.range_error = out_err_q;

endmodule
